// ----- hw/rtl/ttd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants for the token trie recognizer.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int NODE_DEPTH_DEF   = 1024;
  localparam int CHOICE_DEPTH_DEF = 256;
  localparam int SEQ_MAX_DEF      = 64;
  localparam int TOKEN_BITS_DEF   = 16;

  localparam logic [15:0] NO_CHOICE = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_INSPECT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_VOCAB   = 3'd0,
    REG_SEQ     = 3'd1,
    REG_CHOICES = 3'd2,
    REG_STATES  = 3'd3,
    REG_ARCS    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] token;
    logic [15:0] choice_id;
    logic        last_token;
    logic [9:0]  query_state;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  next_state;
    logic        terminal;
    logic [15:0] result_choice;
    logic [9:0]  outgoing_arcs;
  } result_t;

endpackage

// ----- hw/rtl/ttd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_front
// Accepts requests into a short queue that feeds the trie engine.
// ----------------------------------------------------------------------------
module ttd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ttd_pkg::request_t req,
  output logic              busy,
  output logic              q_valid,
  output ttd_pkg::request_t q_req,
  input  logic              q_pop
);
  import ttd_pkg::*;

  request_t   fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_req   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    !(count == 2'd2 && push)) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    !(count == 2'd0 && q_pop)) else $error("queue underflow");
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_valid) else $error("busy with empty queue");
`endif

endmodule

// ----- hw/rtl/ttd_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_engine
// Executes requests against the trie tables, one table row per cycle.
// ----------------------------------------------------------------------------
module ttd_engine #(
  parameter int NODE_DEPTH   = ttd_pkg::NODE_DEPTH_DEF,
  parameter int CHOICE_DEPTH = ttd_pkg::CHOICE_DEPTH_DEF,
  parameter int SEQ_MAX      = ttd_pkg::SEQ_MAX_DEF,
  parameter int TOKEN_BITS   = ttd_pkg::TOKEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [16:0]       cfg_data,
  input  logic              q_valid,
  input  ttd_pkg::request_t q_req,
  output logic              q_pop,
  output logic              done,
  output ttd_pkg::result_t  res
);
  import ttd_pkg::*;

  localparam int NB  = $clog2(NODE_DEPTH);
  localparam int NT  = $clog2(NODE_DEPTH + 1);
  localparam int CB  = (CHOICE_DEPTH > 1) ? $clog2(CHOICE_DEPTH) : 1;
  localparam int CT  = $clog2(CHOICE_DEPTH + 1);
  localparam int SB  = $clog2(SEQ_MAX + 1);
  localparam int KW  = NB + TOKEN_BITS;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_IDSCAN = 9'b000000100,
    S_CHECK  = 9'b000001000,
    S_NSCAN  = 9'b000010000,
    S_STEP   = 9'b000100000,
    S_RDNODE = 9'b001000000,
    S_RDCH   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [16:0] vocab;
  logic [6:0]  max_seq;
  logic [8:0]  max_ch;
  logic [10:0] max_st;
  logic [9:0]  max_arc;

  logic [KW-1:0] key_mem  [NODE_DEPTH];
  logic [CB-1:0] tidx_mem [NODE_DEPTH];
  logic [NT-1:0] cnt_mem  [NODE_DEPTH];
  logic [15:0]   ch_mem   [CHOICE_DEPTH];
  logic          term_v   [NODE_DEPTH];

  logic [NT-1:0] node_total;
  logic [CT-1:0] choice_total;
  logic [NB-1:0] walk_node;
  logic [SB-1:0] seq_len;
  logic [1:0]    build_error;

  request_t      r;
  logic [NT-1:0] scan_n;
  logic [CT-1:0] scan_c;
  logic [KW-1:0] key_rd;
  logic [15:0]   ch_rd;
  logic [CB-1:0] tidx_rd;
  logic [NT-1:0] cnt_rd;
  logic          term_rd;
  logic [NB-1:0] rep_n;
  logic [NB-1:0] child;
  logic          found;
  logic          created;
  logic [KW-1:0] want_key;
  logic [NB-1:0] base_node;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign base_node = (r.cmd == CMD_INSERT) ? walk_node : NB'(r.query_state);
  assign want_key  = {base_node, TOKEN_BITS'(r.token)};

  always_ff @(posedge clk) begin
    key_rd  <= key_mem[scan_n[NB-1:0]];
    ch_rd   <= ch_mem[(state == S_RDCH) ? tidx_rd : scan_c[CB-1:0]];
    tidx_rd <= tidx_mem[rep_n];
    cnt_rd  <= cnt_mem[(state == S_RDNODE) ? rep_n : walk_node];
    term_rd <= term_v[(state == S_RDNODE) ? rep_n : walk_node];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vocab <= 17'd65536; max_seq <= 7'd64; max_ch <= 9'd256;
      max_st <= 11'd1024; max_arc <= 10'd1023;
      node_total <= NT'(1); choice_total <= '0; walk_node <= '0;
      seq_len <= '0; build_error <= 2'd0; done <= 1'b0;
      cnt_mem[0] <= '0; term_v[0] <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VOCAB:   vocab   <= cfg_data;
          REG_SEQ:     max_seq <= cfg_data[6:0];
          REG_CHOICES: max_ch  <= cfg_data[8:0];
          REG_STATES:  max_st  <= cfg_data[10:0];
          REG_ARCS:    max_arc <= cfg_data[9:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            r     <= q_req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res <= '{status: ST_OK, next_state: '0, terminal: 1'b0,
                   result_choice: NO_CHOICE, outgoing_arcs: '0};
          scan_n <= NT'(1); scan_c <= '0; found <= 1'b0; created <= 1'b0;
          unique case (r.cmd)
            CMD_CLEAR: begin
              node_total <= NT'(1); choice_total <= '0; walk_node <= '0;
              seq_len <= '0; build_error <= 2'd0;
              cnt_mem[0] <= '0; term_v[0] <= 1'b0;
              state <= S_OUT;
            end
            CMD_INSERT: begin
              if (build_error != 2'd0) begin
                state <= S_OUT;
              end else if (vocab == 0 || max_seq == 0 || max_ch == 0 ||
                           max_st == 0 || max_arc == 0) begin
                build_error <= ST_INVALID; state <= S_OUT;
              end else if (r.last_token && r.choice_id == NO_CHOICE) begin
                build_error <= ST_INVALID; state <= S_OUT;
              end else begin
                state <= S_IDSCAN;
              end
            end
            default: begin
              if (!(build_error == 0 && walk_node == 0 && seq_len == 0 &&
                    choice_total != 0)) begin
                res.status <= ST_NOT_READY; state <= S_OUT;
              end else if ({1'b0, r.query_state} >= 11'(node_total) ||
                           32'(r.query_state) >= NODE_DEPTH) begin
                res.status <= ST_INVALID; state <= S_OUT;
              end else if (r.cmd == CMD_INSPECT) begin
                rep_n <= NB'(r.query_state); state <= S_RDNODE;
              end else begin
                state <= S_NSCAN;
              end
            end
          endcase
        end
        S_IDSCAN: begin
          if (!r.last_token || scan_c >= choice_total) begin
            state <= S_CHECK;
          end else begin
            scan_c <= scan_c + CT'(1);
            if (scan_c != 0 && ch_rd == r.choice_id) begin
              build_error <= ST_INVALID; state <= S_OUT;
            end
          end
          if (r.last_token && scan_c >= choice_total && scan_c != 0 &&
              ch_rd == r.choice_id) begin
            build_error <= ST_INVALID; state <= S_OUT;
          end
        end
        S_CHECK: begin
          if (32'(seq_len) + 1 > 32'(max_seq) || 32'(seq_len) + 1 > SEQ_MAX) begin
            build_error <= ST_INVALID; state <= S_OUT;
          end else if ({1'b0, r.token} >= vocab) begin
            build_error <= ST_INVALID; state <= S_OUT;
          end else if (term_rd) begin
            build_error <= ST_INVALID; state <= S_OUT;
          end else begin
            state <= S_NSCAN;
          end
        end
        S_NSCAN: begin
          if (scan_n != NT'(1) && key_rd == want_key && !found) begin
            found <= 1'b1;
            child <= NB'(scan_n - NT'(1));
          end
          if (found || (scan_n != NT'(1) && key_rd == want_key) ||
              scan_n >= node_total || 32'(scan_n) >= NODE_DEPTH) begin
            state <= (r.cmd == CMD_INSERT) ? S_STEP : S_RDNODE;
            if (r.cmd != CMD_INSERT) begin
              rep_n <= (scan_n != NT'(1) && key_rd == want_key && !found) ?
                       NB'(scan_n - NT'(1)) : child;
              if (!found && !(scan_n != NT'(1) && key_rd == want_key)) begin
                res.status <= ST_INVALID; state <= S_OUT;
              end
            end
          end else begin
            scan_n <= scan_n + NT'(1);
          end
        end
        S_STEP: begin
          if (!found) begin
            if (11'(node_total) >= max_st || 32'(node_total) >= NODE_DEPTH ||
                10'(node_total - NT'(1)) >= max_arc ||
                32'(node_total - NT'(1)) >= 32'(max_arc)) begin
              build_error <= ST_LIMIT; state <= S_OUT;
            end else begin
              key_mem[node_total[NB-1:0]]  <= want_key;
              cnt_mem[node_total[NB-1:0]]  <= '0;
              term_v[node_total[NB-1:0]]   <= 1'b0;
              node_total <= node_total + NT'(1);
              child <= node_total[NB-1:0];
              found <= 1'b1;
              created <= 1'b1;
            end
          end else begin
            if (created) begin
              cnt_mem[walk_node] <= cnt_rd + NT'(1);
            end
            walk_node <= child;
            seq_len   <= seq_len + SB'(1);
            res.next_state <= 10'(child);
            state <= S_OUT;
            if (r.last_token) begin
              rep_n <= child; state <= S_RDNODE;
            end
          end
        end
        S_RDNODE: begin
          state <= S_RDCH;
        end
        S_RDCH: begin
          if (r.cmd == CMD_INSERT) begin
            if (term_rd || cnt_rd != 0) begin
              build_error <= ST_INVALID; state <= S_OUT;
            end else if (32'(choice_total) >= 32'(max_ch) ||
                         32'(choice_total) >= CHOICE_DEPTH) begin
              build_error <= ST_LIMIT; state <= S_OUT;
            end else begin
              term_v[rep_n]   <= 1'b1;
              tidx_mem[rep_n] <= CB'(choice_total);
              ch_mem[choice_total[CB-1:0]] <= r.choice_id;
              choice_total <= choice_total + CT'(1);
              walk_node <= '0; seq_len <= '0;
              res.next_state <= '0;
              state <= S_OUT;
            end
          end else begin
            res.next_state    <= 10'(rep_n);
            res.outgoing_arcs <= 10'(cnt_rd);
            res.terminal      <= term_rd;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (r.cmd == CMD_INSERT) begin
            res.status     <= (build_error != 0) ? build_error : ST_OK;
            res.next_state <= 10'(walk_node);
          end else if (res.terminal) begin
            res.result_choice <= ch_rd;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_DECODE) else $error("pop outside idle");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double strobe");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    32'(walk_node) < 32'(node_total)) else $error("walk past table");
`endif

endmodule

// ----- hw/rtl/token_trie_dfa.sv -----
`timescale 1ns / 1ps
// Clear, refused requests and inserts failing at decode go straight to output;
// inspect reads the node and its choice; advance scans the nodes for the child
// first; insert checks its limits, scans the nodes and steps to or creates the
// child, scanning the stored choice IDs too when it carries the last token. The
// engine pops the next request in the cycle that strobes each result; a two-entry queue accepts meanwhile.
// Synchronous reset restores default registers and an empty trie; no stall on results.
// ----------------------------------------------------------------------------
// token_trie_dfa
// Top level: request queue in front of the trie engine.
// ----------------------------------------------------------------------------
module token_trie_dfa #(
  parameter int NODE_DEPTH   = ttd_pkg::NODE_DEPTH_DEF,
  parameter int CHOICE_DEPTH = ttd_pkg::CHOICE_DEPTH_DEF,
  parameter int SEQ_MAX      = ttd_pkg::SEQ_MAX_DEF,
  parameter int TOKEN_BITS   = ttd_pkg::TOKEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ttd_pkg::request_t req,
  output logic              done,
  output ttd_pkg::result_t  res,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [16:0]       cfg_data
);
  import ttd_pkg::*;

  logic     q_valid;
  logic     q_pop;
  request_t q_req;

  ttd_front u_front (
    .clk, .rst, .start, .req, .busy, .q_valid, .q_req, .q_pop
  );

  ttd_engine #(
    .NODE_DEPTH(NODE_DEPTH), .CHOICE_DEPTH(CHOICE_DEPTH),
    .SEQ_MAX(SEQ_MAX), .TOKEN_BITS(TOKEN_BITS)
  ) u_engine (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_req, .q_pop, .done, .res
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the token trie recognizer. Requests are driven in
// random bursts, mostly well-formed choice sequences with random content, and
// every strobed result is compared with a behavioral trie kept alongside.
// ----------------------------------------------------------------------------
class trie_scoreboard;
  logic [16:0] vocab;
  logic [6:0]  seq_lim;
  logic [8:0]  choice_lim;
  logic [10:0] state_lim;
  logic [9:0]  arc_lim;
  logic [25:0] parent_key [1024];
  logic [8:0]  term_index [1024];
  bit          is_term    [1024];
  logic [10:0] child_cnt  [1024];
  logic [15:0] choice_mem [256];
  int unsigned node_count, choice_count, walk, seq_len;
  ttd_pkg::status_t build_err;
  ttd_pkg::result_t pending [$];
  int errors;

  function new();
    vocab = 17'd65536; seq_lim = 7'd64; choice_lim = 9'd256;
    state_lim = 11'd1024; arc_lim = 10'd1023; errors = 0;
    wipe();
  endfunction

  function void set_reg(ttd_pkg::reg_idx_t idx, logic [16:0] v);
    case (idx)
      ttd_pkg::REG_VOCAB:   vocab = v;
      ttd_pkg::REG_SEQ:     seq_lim = v[6:0];
      ttd_pkg::REG_CHOICES: choice_lim = v[8:0];
      ttd_pkg::REG_STATES:  state_lim = v[10:0];
      ttd_pkg::REG_ARCS:    arc_lim = v[9:0];
      default: ;
    endcase
  endfunction

  function void make_node(int unsigned n);
    is_term[n] = 0; term_index[n] = 0; child_cnt[n] = 0; parent_key[n] = 0;
  endfunction

  function void wipe();
    make_node(0);
    node_count = 1; choice_count = 0; walk = 0; seq_len = 0;
    build_err = ttd_pkg::ST_OK;
  endfunction

  function int unsigned lookup(int unsigned p, logic [15:0] tok);
    logic [25:0] key;
    key = {p[9:0], tok};
    for (int unsigned i = 1; i < node_count; i++)
      if (parent_key[i] == key) return i;
    return 0;
  endfunction

  function bit id_used(logic [15:0] id);
    for (int unsigned i = 0; i < choice_count; i++)
      if (choice_mem[i] == id) return 1;
    return 0;
  endfunction

  function ttd_pkg::status_t add_token(logic [15:0] tok, logic [15:0] id, bit last);
    int unsigned c;
    if (vocab == 0 || seq_lim == 0 || choice_lim == 0 || state_lim == 0 || arc_lim == 0)
      return ttd_pkg::ST_INVALID;
    if (last && (id == ttd_pkg::NO_CHOICE || id_used(id))) return ttd_pkg::ST_INVALID;
    if (seq_len + 1 > seq_lim || seq_len + 1 > ttd_pkg::SEQ_MAX_DEF)
      return ttd_pkg::ST_INVALID;
    if ({1'b0, tok} >= vocab) return ttd_pkg::ST_INVALID;
    if (is_term[walk]) return ttd_pkg::ST_INVALID;
    c = lookup(walk, tok);
    if (c == 0) begin
      if (node_count >= state_lim || node_count >= 1024 || node_count - 1 >= arc_lim)
        return ttd_pkg::ST_LIMIT;
      c = node_count;
      make_node(c);
      parent_key[c] = {walk[9:0], tok};
      child_cnt[walk]++;
      node_count++;
    end
    walk = c;
    seq_len++;
    if (!last) return ttd_pkg::ST_OK;
    if (is_term[walk] || child_cnt[walk] != 0) return ttd_pkg::ST_INVALID;
    if (choice_count >= choice_lim || choice_count >= 256) return ttd_pkg::ST_LIMIT;
    is_term[walk] = 1'b1;
    term_index[walk] = 9'(choice_count);
    choice_mem[choice_count] = id;
    choice_count++;
    walk = 0;
    seq_len = 0;
    return ttd_pkg::ST_OK;
  endfunction

  function void note_request(ttd_pkg::request_t r);
    ttd_pkg::result_t e;
    int unsigned c, n;
    e = '{status: ttd_pkg::ST_OK, next_state: '0, terminal: 1'b0,
          result_choice: ttd_pkg::NO_CHOICE, outgoing_arcs: '0};
    if (r.cmd == ttd_pkg::CMD_CLEAR) begin
      wipe();
    end else if (r.cmd == ttd_pkg::CMD_INSERT) begin
      if (build_err == ttd_pkg::ST_OK)
        build_err = add_token(r.token, r.choice_id, r.last_token);
      e.status = build_err;
      e.next_state = walk[9:0];
    end else if (!(build_err == ttd_pkg::ST_OK && walk == 0 && seq_len == 0 &&
                   choice_count > 0)) begin
      e.status = ttd_pkg::ST_NOT_READY;
    end else if (r.query_state >= node_count) begin
      e.status = ttd_pkg::ST_INVALID;
    end else begin
      n = r.query_state;
      c = (r.cmd == ttd_pkg::CMD_INSPECT) ? n : lookup(n, r.token);
      if (c == 0 && r.cmd == ttd_pkg::CMD_ADVANCE) begin
        e.status = ttd_pkg::ST_INVALID;
      end else begin
        e.next_state = c[9:0];
        if (is_term[c]) begin
          e.terminal = 1'b1;
          e.result_choice = choice_mem[term_index[c]];
        end
        e.outgoing_arcs = child_cnt[c][9:0];
      end
    end
    pending = {pending, e};
  endfunction

  function void check_result(ttd_pkg::result_t got);
    ttd_pkg::result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got !== e) begin
      $display("%0t: mismatch expected st=%0d ns=%0d t=%0d ch=%h arcs=%0d", $realtime,
               e.status, e.next_state, e.terminal, e.result_choice, e.outgoing_arcs);
      $display("%0t:          actual   st=%0d ns=%0d t=%0d ch=%h arcs=%0d", $realtime,
               got.status, got.next_state, got.terminal, got.result_choice,
               got.outgoing_arcs);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ttd_pkg::*;

  localparam int LIMIT = 12_000_000;

  logic clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic busy, done;
  request_t req = '0;
  result_t res;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  int cycles = 0;
  int burst_left = 0;
  trie_scoreboard sb = new();
  logic [15:0] tok_pool [8];

  token_trie_dfa u_dut (.clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(res);
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send(cmd_t c, logic [15:0] tok, logic [15:0] id, bit last, logic [9:0] q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    req = '{cmd: c, token: tok, choice_id: id, last_token: last, query_state: q};
    start = 1;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [16:0] v);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, v);
  endtask

  task automatic queries(int n);
    logic [9:0] q;
    for (int i = 0; i < n; i++) begin
      q = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, sb.node_count));
      send($urandom_range(0, 1) ? CMD_ADVANCE : CMD_INSPECT,
           $urandom_range(0, 1) ? tok_pool[$urandom_range(0, 7)] : 16'($urandom),
           16'($urandom), $urandom_range(0, 1), q);
    end
  endtask

  task automatic build_phase(int seqs);
    int len;
    logic [15:0] id;
    for (int i = 0; i < 8; i++) tok_pool[i] = 16'($urandom_range(0, 40));
    send(CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom_range(0, 1), 10'($urandom));
    for (int s = 0; s < seqs; s++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        id = ($urandom_range(0, 30) == 0) ? NO_CHOICE :
             ($urandom_range(0, 20) == 0) ? 16'(s) : 16'($urandom);
        send(CMD_INSERT,
             ($urandom_range(0, 15) == 0) ? 16'($urandom) : tok_pool[$urandom_range(0, 7)],
             id, (k == len - 1) || ($urandom_range(0, 40) == 0), 10'($urandom));
      end
      if ($urandom_range(0, 3) == 0) queries(2);
    end
    queries(12);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 0;
    send(CMD_INSPECT, 16'h0, 16'h0, 0, 10'h0);
    send(CMD_INSERT, 16'hFFFF, 16'hFFFE, 0, 10'h3FF);
    send(CMD_INSERT, 16'h0001, NO_CHOICE, 1, 10'h0);
    send(CMD_CLEAR, 16'h0, 16'h0, 0, 10'h0);
    send(CMD_INSERT, 16'hFFFF, 16'h0000, 0, 10'h0);
    send(CMD_INSERT, 16'h0000, 16'h0001, 1, 10'h0);
    send(CMD_INSERT, 16'hFFFF, 16'h0002, 1, 10'h0);
    send(CMD_INSERT, 16'h0005, 16'h0002, 1, 10'h0);
    send(CMD_INSERT, 16'hFFFF, 16'h0003, 0, 10'h0);
    send(CMD_INSERT, 16'h0000, 16'h0004, 1, 10'h0);
    send(CMD_INSERT, 16'h0007, 16'hFFFE, 1, 10'h0);
    send(CMD_ADVANCE, 16'hFFFF, 16'h0, 0, 10'h0);
    send(CMD_ADVANCE, 16'h0000, 16'h0, 0, 10'h1);
    send(CMD_ADVANCE, 16'h1234, 16'h0, 0, 10'h0);
    send(CMD_INSPECT, 16'h0, 16'h0, 0, 10'h0);
    send(CMD_INSPECT, 16'h0, 16'h0, 0, 10'h2);
    send(CMD_INSPECT, 16'h0, 16'h0, 1, 10'h3FF);
    send(CMD_INSERT, 16'h0009, 16'h0009, 0, 10'h0);
    send(CMD_INSERT, 16'h0009, 16'h0009, 0, 10'h0);
    send(CMD_INSPECT, 16'h0, 16'h0, 0, 10'h0);
    send(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1, 10'h3FF);
    send(CMD_INSERT, 16'h0002, 16'h0000, 1, 10'h0);
    send(CMD_INSPECT, 16'hFFFF, 16'hFFFF, 1, 10'h1);
    drain();
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 6)
        0: begin
          write_reg(REG_VOCAB, 17'd65536); write_reg(REG_SEQ, 7'd64);
          write_reg(REG_CHOICES, 9'd256); write_reg(REG_STATES, 11'd1024);
          write_reg(REG_ARCS, 10'd1023);
        end
        1: begin
          write_reg(REG_VOCAB, 17'd1); write_reg(REG_SEQ, 7'd1);
          write_reg(REG_CHOICES, 9'd1); write_reg(REG_STATES, 11'd1);
          write_reg(REG_ARCS, 10'd1);
        end
        2: begin
          write_reg(REG_VOCAB, 17'($urandom_range(1, 40)));
          write_reg(REG_SEQ, 7'($urandom_range(1, 6)));
          write_reg(REG_CHOICES, 9'($urandom_range(1, 12)));
          write_reg(REG_STATES, 11'($urandom_range(2, 30)));
          write_reg(REG_ARCS, 10'($urandom_range(1, 30)));
        end
        3: write_reg(reg_idx_t'($urandom_range(0, 4)), 17'd0);
        4: write_reg(reg_idx_t'($urandom_range(0, 4)), 17'($urandom));
        default: begin
          write_reg(REG_VOCAB, 17'd65536); write_reg(REG_SEQ, 7'($urandom_range(1, 64)));
          write_reg(REG_CHOICES, 9'($urandom_range(1, 256)));
          write_reg(REG_STATES, 11'($urandom_range(1, 1024)));
          write_reg(REG_ARCS, 10'($urandom_range(1, 1023)));
        end
      endcase
      build_phase($urandom_range(8, 25));
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
